FILE: rtl/hypo_pkg.sv
// Shared constants, types and polynomial table for the hypotrochoid point generator.
package hypo_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_RING   = 3'd0;
    localparam logic [2:0] REG_WHEEL  = 3'd1;
    localparam logic [2:0] REG_PEN    = 3'd2;
    localparam logic [2:0] REG_CX     = 3'd3;
    localparam logic [2:0] REG_CY     = 3'd4;
    localparam logic [2:0] REG_STEP   = 3'd5;
    localparam logic [2:0] REG_POINTS = 3'd6;

    localparam int Q30_W = 31;

    // Taylor coefficients of sin(pi/2*z) in Q30, index 0 is the linear term.
    function automatic logic [Q30_W-1:0] poly_coef(input logic [2:0] idx);
        logic [Q30_W-1:0] c;
        begin
            case (idx)
                3'd0: c = 31'd1686629713;
                3'd1: c = 31'd693598669;
                3'd2: c = 31'd85569305;
                3'd3: c = 31'd5026995;
                3'd4: c = 31'd172272;
                default: c = 31'd3864;
            endcase
            return c;
        end
    endfunction

    // Request to the shared sine unit.
    typedef struct packed {
        logic start;
        logic cosine;
    } sin_req_t;

endpackage

FILE: rtl/hypo_div.sv
// Radix-2 restoring divider shared for the second phase step and the pen gain.
module hypo_div import hypo_pkg::*; #(
    parameter int NW = 59,
    parameter int DW = 11
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] numer,
    input  logic [DW-1:0] denom,
    output logic          done,
    output logic [NW-1:0] quot
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW+1:0] trial;

    // One quotient bit per cycle.
    always_comb begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, q_reg[NW-1]} - {2'b00, denom};
        if (start) begin
            q_next    = numer;
            rem_next  = '0;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[DW+1]) begin
                rem_next = trial[DW:0];
                q_next   = {q_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[DW-1:0], q_reg[NW-1]};
                q_next   = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

FILE: rtl/hypo_sine.sv
// Iterative quarter-wave sine unit using one shared multiplier.
module hypo_sine import hypo_pkg::*; #(
    parameter int PB = 32,
    parameter int SF = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  sin_req_t            req,
    input  logic [PB-1:0]       phase,
    output logic                done,
    output logic signed [SF+1:0] value
);
    localparam int QB = PB - 2;
    localparam logic [Q30_W-1:0] ONE = 31'(1) << 30;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_Z2   = 3'd1;
    localparam logic [2:0] S_HORN = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]       st_reg, st_next;
    logic [2:0]       k_reg, k_next;
    logic [Q30_W-1:0] z_reg, z_next, z2_reg, z2_next, p_reg, p_next;
    logic             neg_reg, neg_next;
    logic signed [SF+1:0] val_reg, val_next;
    logic [PB-1:0]    ph;
    logic [QB-1:0]    rem;
    logic [Q30_W-1:0] zraw;
    logic [Q30_W-1:0] ma, mb;
    logic [2*Q30_W-1:0] prod;
    logic [Q30_W-1:0] prod30;
    logic [Q30_W-1:0] rnd;

    assign ph  = req.cosine ? phase + (PB'(1) << QB) : phase;
    assign rem = ph[QB-1:0];
    generate
        if (QB >= 30) begin : g_shr
            assign zraw = Q30_W'(rem >> (QB - 30));
        end else begin : g_shl
            assign zraw = Q30_W'({rem, {(30 - QB){1'b0}}});
        end
    endgenerate

    // Shared 31x31 multiplier.
    always_comb begin
        case (st_reg)
            S_Z2:    begin ma = z_reg;  mb = z_reg; end
            S_HORN:  begin ma = z2_reg; mb = p_reg; end
            default: begin ma = z_reg;  mb = p_reg; end
        endcase
    end
    assign prod   = ma * mb;
    assign prod30 = prod[30 +: Q30_W];
    assign rnd    = prod30 + (Q30_W'(1) << (29 - SF));

    always_comb begin
        st_next  = st_reg;
        k_next   = k_reg;
        z_next   = z_reg;
        z2_next  = z2_reg;
        p_next   = p_reg;
        neg_next = neg_reg;
        val_next = val_reg;
        unique case (st_reg)
            S_IDLE: begin
                if (req.start) begin
                    z_next   = ph[QB] ? ONE - zraw : zraw;
                    neg_next = ph[QB+1];
                    st_next  = S_Z2;
                end
            end
            S_Z2: begin
                z2_next = prod30;
                p_next  = poly_coef(3'd5);
                k_next  = 3'd4;
                st_next = S_HORN;
            end
            S_HORN: begin
                p_next = poly_coef(k_reg) - prod30;
                if (k_reg == 3'd0) st_next = S_FIN;
                else k_next = k_reg - 1'b1;
            end
            S_FIN: begin
                val_next = neg_reg ? -$signed({1'b0, rnd[30:30-SF]})
                                   :  $signed({1'b0, rnd[30:30-SF]});
                st_next  = S_OUT;
            end
            S_OUT: st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
        end else begin
            st_reg <= st_next;
        end
        k_reg   <= k_next;
        z_reg   <= z_next;
        z2_reg  <= z2_next;
        p_reg   <= p_next;
        neg_reg <= neg_next;
        val_reg <= val_next;
    end

    assign done  = (st_reg == S_OUT);
    assign value = val_reg;
endmodule

FILE: rtl/hypotrochoid_point_generator.sv
// Top level: sequencer, phase state, coordinate accumulation and handshakes.
// From input accept to m_valid: two 44-bit divisions, four sine evaluations,
// then multiply, sum, output. s_ready is low while a point is in work.
// The result register lets the next item be accepted while a point waits.
// Synchronous active-low reset loads register defaults and clears all phases.
module hypotrochoid_point_generator import hypo_pkg::*; #(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_restart,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_x_coord,
    output logic signed [15:0] m_y_coord,
    output logic               m_last_in_frame,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    localparam int PB = PHASE_BITS;
    localparam int SF = SINE_FRAC_BITS;
    localparam int NW = (PB + 12 > 38) ? PB + 12 : 38;
    localparam int AW = 30 + SF;
    localparam int SW = SF + 2;

    localparam logic [3:0] T_IDLE = 4'd0;
    localparam logic [3:0] T_DIV1 = 4'd1;
    localparam logic [3:0] T_WD1  = 4'd2;
    localparam logic [3:0] T_DIV2 = 4'd3;
    localparam logic [3:0] T_WD2  = 4'd4;
    localparam logic [3:0] T_SIN  = 4'd5;
    localparam logic [3:0] T_WSIN = 4'd6;
    localparam logic [3:0] T_ACC  = 4'd7;
    localparam logic [3:0] T_MUL  = 4'd8;
    localparam logic [3:0] T_OUT  = 4'd9;

    // Configuration registers.
    logic [10:0] ring_reg, wheel_reg, pen_reg;
    logic [11:0] cx_reg, cy_reg;
    logic [31:0] step_reg;
    logic [12:0] npts_reg;

    logic [3:0]    st_reg, st_next;
    logic [PB-1:0] fm_reg, fs_reg, pm_reg, ps_reg;
    logic [11:0]   cnt_reg;
    logic          restart_reg;
    logic [PB-1:0] ss_reg;
    logic [31:0]   gain_reg;
    logic [1:0]    sidx_reg;
    logic signed [SW-1:0] c1_reg, s1_reg, c2_reg, s2_reg;
    logic signed [AW+3:0] ax_reg, ay_reg;
    logic signed [SW+12:0] dm_reg, ds_reg;
    logic signed [SW+33:0] gm_reg, gs_reg;
    logic          mv_reg, last_reg;
    logic [15:0]   xo_reg, yo_reg;

    logic [10:0]   rr;
    logic [PB-1:0] ms;
    logic [11:0]   rdiff_mag;
    logic          rneg;
    logic signed [12:0] diff;
    logic [12:0]   n_eff;
    logic          last_pt;
    logic          div_start, div_done;
    logic [NW-1:0] div_num, div_q;
    sin_req_t      sreq;
    logic          sdone;
    logic signed [SW-1:0] sval;
    logic [PB-1:0] sphase;
    logic          in_acc;

    assign rr = (ring_reg == 11'd0) ? 11'd1 : ring_reg;
    generate
        if (PB >= 32) begin : g_msl
            assign ms = PB'(step_reg) << (PB - 32);
        end else begin : g_msr
            assign ms = PB'(step_reg >> (32 - PB));
        end
    endgenerate
    assign rneg      = wheel_reg > rr;
    assign rdiff_mag = rneg ? 12'(wheel_reg - rr) : 12'(rr - wheel_reg);
    assign diff      = $signed({2'b00, rr}) - $signed({2'b00, wheel_reg});
    assign n_eff     = (npts_reg == 13'd0) ? 13'd1 :
                       (npts_reg > 13'd4096) ? 13'd4096 : npts_reg;
    assign last_pt   = ({1'b0, cnt_reg} + 13'd1) >= n_eff;
    assign in_acc    = s_valid && s_ready;

    // Divider operand select: second phase step, then pen gain.
    assign div_start = (st_reg == T_DIV1) || (st_reg == T_DIV2);
    assign div_num   = (st_reg == T_DIV1) ? NW'(rdiff_mag) * NW'(ms)
                                          : NW'({22'(pen_reg) * 22'(wheel_reg), 16'h0000});

    hypo_div #(.NW(NW), .DW(11)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .numer(div_num), .denom(rr), .done(div_done), .quot(div_q)
    );

    assign sphase      = sidx_reg[1] ? ps_reg : pm_reg;
    assign sreq.start  = (st_reg == T_SIN);
    assign sreq.cosine = !sidx_reg[0];

    hypo_sine #(.PB(PB), .SF(SF)) u_sine (
        .aclk(aclk), .aresetn(aresetn), .req(sreq), .phase(sphase),
        .done(sdone), .value(sval)
    );

    // Pixel rounding and saturation of an accumulated coordinate.
    function automatic logic [15:0] to_pix(input logic signed [AW+3:0] a);
        logic signed [AW+3:0] r;
        logic signed [AW+3-(16+SF):0] v;
        begin
            r = a + ((AW+4)'(1) << (15 + SF));
            v = (AW+4-(16+SF))'(r >>> (16 + SF));
            if (v > 32767) return 16'h7FFF;
            else if (v < -32768) return 16'h8000;
            else return v[15:0];
        end
    endfunction

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            T_IDLE: if (in_acc) st_next = T_DIV1;
            T_DIV1: st_next = T_WD1;
            T_WD1:  if (div_done) st_next = T_DIV2;
            T_DIV2: st_next = T_WD2;
            T_WD2:  if (div_done) st_next = T_SIN;
            T_SIN:  st_next = T_WSIN;
            T_WSIN: if (sdone) st_next = (sidx_reg == 2'd3) ? T_MUL : T_SIN;
            T_MUL:  st_next = T_ACC;
            T_ACC:  st_next = T_OUT;
            T_OUT:  if (!mv_reg || m_ready) st_next = T_IDLE;
            default: st_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_reg <= 11'd200; wheel_reg <= 11'd70; pen_reg <= 11'd50;
            cx_reg <= 12'd960; cy_reg <= 12'd540;
            step_reg <= 32'd42949673; npts_reg <= 13'd500;
            st_reg <= T_IDLE;
            fm_reg <= '0; fs_reg <= '0; pm_reg <= '0; ps_reg <= '0;
            cnt_reg <= '0;
            mv_reg <= 1'b0;
            sidx_reg <= '0;
        end else begin
            st_reg <= st_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_RING:   ring_reg  <= cfg_data[10:0];
                    REG_WHEEL:  wheel_reg <= cfg_data[10:0];
                    REG_PEN:    pen_reg   <= cfg_data[10:0];
                    REG_CX:     cx_reg    <= cfg_data[11:0];
                    REG_CY:     cy_reg    <= cfg_data[11:0];
                    REG_STEP:   step_reg  <= cfg_data;
                    REG_POINTS: npts_reg  <= cfg_data[12:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                restart_reg <= s_restart;
                sidx_reg    <= '0;
            end
            // Second step ready: apply restart and advance point phases.
            if (st_reg == T_WD1 && div_done) begin
                ss_reg <= rneg ? PB'(0) - PB'(div_q) : PB'(div_q);
                if (restart_reg) begin
                    fm_reg <= '0; fs_reg <= '0; cnt_reg <= '0;
                    pm_reg <= ms;
                    ps_reg <= rneg ? PB'(0) - PB'(div_q) : PB'(div_q);
                end else begin
                    pm_reg <= pm_reg + ms;
                    ps_reg <= ps_reg + (rneg ? PB'(0) - PB'(div_q) : PB'(div_q));
                end
            end
            if (st_reg == T_WD2 && div_done) begin
                gain_reg <= (div_q > NW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : div_q[31:0];
            end
            if (st_reg == T_WSIN && sdone) begin
                unique case (sidx_reg)
                    2'd0: c1_reg <= sval;
                    2'd1: s1_reg <= sval;
                    2'd2: c2_reg <= sval;
                    default: s2_reg <= sval;
                endcase
                sidx_reg <= sidx_reg + 2'd1;
            end
            // Products registered before the sums.
            if (st_reg == T_MUL) begin
                dm_reg <= diff * c1_reg;
                ds_reg <= diff * s1_reg;
                gm_reg <= $signed({2'b00, gain_reg}) * c2_reg;
                gs_reg <= $signed({2'b00, gain_reg}) * s2_reg;
            end
            if (st_reg == T_ACC) begin
                ax_reg <= ((AW+4)'($signed({1'b0, cx_reg})) <<< (16 + SF))
                        + ((AW+4)'(dm_reg) <<< 16) + (AW+4)'(gm_reg);
                ay_reg <= ((AW+4)'($signed({1'b0, cy_reg})) <<< (16 + SF))
                        + ((AW+4)'(ds_reg) <<< 16) - (AW+4)'(gs_reg);
            end
            // Publish the point, or clear the valid flag once the item is taken.
            if (st_reg == T_OUT && (!mv_reg || m_ready)) begin
                mv_reg   <= 1'b1;
                xo_reg   <= to_pix(ax_reg);
                yo_reg   <= to_pix(ay_reg);
                last_reg <= last_pt;
                if (last_pt) begin
                    fm_reg  <= fm_reg + ms;
                    fs_reg  <= fs_reg + ss_reg;
                    pm_reg  <= fm_reg + ms;
                    ps_reg  <= fs_reg + ss_reg;
                    cnt_reg <= '0;
                end else begin
                    cnt_reg <= cnt_reg + 12'd1;
                end
            end else if (m_valid && m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    assign s_ready         = (st_reg == T_IDLE);
    assign cfg_ready       = (st_reg == T_IDLE);
    assign m_valid         = mv_reg;
    assign m_x_coord       = xo_reg;
    assign m_y_coord       = yo_reg;
    assign m_last_in_frame = last_reg;

    // The block takes no item while a point is in work.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg != T_IDLE) |-> !s_ready) else $error("ready while busy");
    // An accepted item always starts the step division.
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> (st_reg == T_DIV1)) else $error("item did not start");
    // A result is published only from the output state.
    a_pub: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(st_reg) == T_OUT)) else $error("stray result");
endmodule
